// ===== rtl/core/lpcf_pkg.sv =====
package lpcf_pkg;

  localparam int unsigned CapWidth = 18;
  localparam int unsigned WrWidth = 31;

  localparam logic [CapWidth-1:0] CAP_RESET = 18'd131080;
  localparam logic [CapWidth-1:0] CAP_MIN = 18'd12;

  localparam logic [1:0] CMD_DATA = 2'd0;
  localparam logic [1:0] CMD_FLUSH = 2'd1;
  localparam logic [1:0] CMD_CLOSE = 2'd2;

  localparam logic [7:0] MARK_FF = 8'hFF;
  localparam logic [7:0] MARK_FE = 8'hFE;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw = $clog2(QDepth);
  localparam int unsigned QCw = QAw + 1;

  typedef struct packed {
    logic                m1;
    logic                hdr;
    logic [CapWidth-1:0] len;
    logic                dat;
    logic [7:0]          data;
    logic                cls;
  } job_t;

endpackage

// ===== rtl/core/lpcf_front.sv =====
module lpcf_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          chunk_capacity_we,
  input  logic [lpcf_pkg::CapWidth-1:0] chunk_capacity,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    command,
  input  logic [7:0]                    data_byte,
  input  logic [lpcf_pkg::WrWidth-1:0]  write_remaining,
  input  logic                          q_full,
  output logic                          q_push,
  output lpcf_pkg::job_t                q_job
);
  import lpcf_pkg::*;

  logic [CapWidth-1:0] cap;
  logic                chunk_open, chunk_open_next;
  logic                stream_closed, stream_closed_next;
  logic [CapWidth-1:0] chunk_room, chunk_room_next;
  logic [CapWidth-1:0] segment_left, segment_left_next;

  logic                accept;
  logic                emit;
  logic [CapWidth-1:0] eff_cap;
  logic                reopen;
  logic [CapWidth-1:0] room_eff;
  logic [CapWidth-1:0] avail;
  logic [WrWidth-1:0]  wr_eff;
  logic [CapWidth-1:0] seg_len;
  job_t                job;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign eff_cap  = (cap < CAP_MIN) ? CAP_MIN : cap;
  assign reopen   = !chunk_open || (chunk_room <= 18'd8);
  assign room_eff = reopen ? eff_cap : chunk_room;
  assign avail    = room_eff - 18'd8;
  assign wr_eff   = (write_remaining == '0) ? WrWidth'(1) : write_remaining;
  assign seg_len  = ({{(WrWidth-CapWidth){1'b0}}, avail} > wr_eff) ?
                    wr_eff[CapWidth-1:0] : avail;

  always_comb begin
    chunk_open_next    = chunk_open;
    stream_closed_next = stream_closed;
    chunk_room_next    = chunk_room;
    segment_left_next  = segment_left;
    job                = '0;
    job.data           = data_byte;
    emit               = 1'b0;
    if (!stream_closed) begin
      case (command)
        CMD_DATA: begin
          emit    = 1'b1;
          job.dat = 1'b1;
          if (segment_left == '0) begin
            job.m1            = chunk_open && (chunk_room <= 18'd8);
            job.hdr           = 1'b1;
            job.len           = seg_len;
            chunk_open_next   = 1'b1;
            chunk_room_next   = room_eff - 18'd4 - seg_len;
            segment_left_next = seg_len - 18'd1;
          end else begin
            segment_left_next = segment_left - 18'd1;
          end
        end
        CMD_FLUSH: begin
          emit              = chunk_open;
          job.m1            = chunk_open;
          chunk_open_next   = 1'b1;
          chunk_room_next   = eff_cap;
          segment_left_next = '0;
        end
        CMD_CLOSE: begin
          if (chunk_open) begin
            emit               = 1'b1;
            job.m1             = chunk_room < 18'd4;
            job.cls            = 1'b1;
            chunk_open_next    = 1'b0;
            stream_closed_next = 1'b1;
            segment_left_next  = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign q_push = accept && emit;
  assign q_job  = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap           <= CAP_RESET;
      chunk_open    <= 1'b0;
      stream_closed <= 1'b0;
      chunk_room    <= CAP_RESET;
      segment_left  <= '0;
    end else begin
      if (chunk_capacity_we) begin
        cap <= chunk_capacity;
      end
      if (accept) begin
        chunk_open    <= chunk_open_next;
        stream_closed <= stream_closed_next;
        chunk_room    <= chunk_room_next;
        segment_left  <= segment_left_next;
      end
    end
  end

endmodule

// ===== rtl/core/lpcf_queue.sv =====
module lpcf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lpcf_pkg::job_t push_job,
  output logic           full,
  output logic           head_valid,
  output lpcf_pkg::job_t head_job,
  input  logic           pop
);
  import lpcf_pkg::*;

  job_t           mem [QDepth];
  logic [QAw-1:0] wr_ptr;
  logic [QAw-1:0] rd_ptr;
  logic [QCw-1:0] count;

  assign full       = (count == QCw'(QDepth));
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAw'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAw'(1);
      end
      if (push && !pop) begin
        count <= count + QCw'(1);
      end else if (pop && !push) begin
        count <= count - QCw'(1);
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCw'(QDepth))
    else $error("queue count out of range");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (push && full) |-> pop)
    else $error("push into full queue");

endmodule

// ===== rtl/core/lpcf_back.sv =====
module lpcf_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  lpcf_pkg::job_t head_job,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           last
);
  import lpcf_pkg::*;

  // pending sections: [4] marker, [3] header, [2] data, [1] end mark, [0] marker
  logic [4:0]          pend;
  logic [4:0]          cur;
  logic [4:0]          pend_after;
  logic [1:0]          cnt;
  logic [CapWidth-1:0] len;
  logic [7:0]          data;
  logic [31:0]         len_word;
  logic                sec_done;
  logic                take;
  logic                load;

  always_comb begin
    cur = '0;
    if (pend[4]) begin
      cur[4] = 1'b1;
    end else if (pend[3]) begin
      cur[3] = 1'b1;
    end else if (pend[2]) begin
      cur[2] = 1'b1;
    end else if (pend[1]) begin
      cur[1] = 1'b1;
    end else if (pend[0]) begin
      cur[0] = 1'b1;
    end
  end

  assign len_word   = {{(32-CapWidth){1'b0}}, len};
  assign out_valid  = (pend != '0);
  assign sec_done   = cur[2] || (cnt == 2'd3);
  assign pend_after = pend & ~cur;
  assign last       = out_valid && sec_done && (pend_after == '0);
  assign take       = out_valid && out_ready;
  assign load       = head_valid && (!out_valid || (take && last));
  assign pop        = load;

  always_comb begin
    out_byte = MARK_FF;
    if (cur[3]) begin
      case (cnt)
        2'd0:    out_byte = len_word[31:24];
        2'd1:    out_byte = len_word[23:16];
        2'd2:    out_byte = len_word[15:8];
        default: out_byte = len_word[7:0];
      endcase
    end else if (cur[2]) begin
      out_byte = data;
    end else if (cur[4] || cur[0]) begin
      out_byte = (cnt == 2'd3) ? MARK_FE : MARK_FF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      cnt  <= '0;
    end else if (load) begin
      pend <= {head_job.m1, head_job.hdr, head_job.dat, head_job.cls, head_job.cls};
      cnt  <= '0;
    end else if (take) begin
      if (sec_done) begin
        pend <= pend_after;
        cnt  <= '0;
      end else begin
        cnt <= cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      len  <= head_job.len;
      data <= head_job.data;
    end
  end

  a_data_single: assert property (@(posedge clk) disable iff (rst)
    cur[2] |-> (cnt == 2'd0))
    else $error("data section with nonzero byte index");

endmodule

// ===== rtl/core/length_prefixed_chunk_framer.sv =====
// a request is stored in the queue, then loaded into the serializer, before its first byte is out
// throughput: one request per cycle with out_ready high and at most one byte per request
// a request yielding n bytes holds the output until all n are out; a 4-entry queue absorbs bursts
// the output serializer (one byte per cycle while out_ready is high) sets the sustained rate
// reset: synchronous, clears chunk and close state, queue and serializer; capacity 131080
module length_prefixed_chunk_framer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          chunk_capacity_we,
  input  logic [lpcf_pkg::CapWidth-1:0] chunk_capacity,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    command,
  input  logic [7:0]                    data_byte,
  input  logic [lpcf_pkg::WrWidth-1:0]  write_remaining,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte,
  output logic                          last
);
  import lpcf_pkg::*;

  logic q_full;
  logic q_push;
  job_t q_job;
  logic head_valid;
  job_t head_job;
  logic q_pop;

  lpcf_front u_front (
    .clk               (clk),
    .rst               (rst),
    .chunk_capacity_we (chunk_capacity_we),
    .chunk_capacity    (chunk_capacity),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .command           (command),
    .data_byte         (data_byte),
    .write_remaining   (write_remaining),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_job             (q_job)
  );

  lpcf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (q_pop)
  );

  lpcf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .last       (last)
  );

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  import lpcf_pkg::*;

  localparam logic [1:0]  CmdUnused   = 2'd3;
  localparam logic [31:0] EndOfChunk  = 32'hFFFF_FFFE;
  localparam logic [31:0] EndOfStream = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } framed_byte_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                chunk_capacity_we = 1'b0;
  logic [CapWidth-1:0] chunk_capacity = CAP_RESET;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          command = CMD_DATA;
  logic [7:0]          data_byte = 8'd0;
  logic [WrWidth-1:0]  write_remaining = 31'd1;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [7:0]          out_byte;
  logic                last;

  // framing state kept by the testbench
  logic [CapWidth-1:0] cfg_cap = CAP_RESET;
  logic [CapWidth-1:0] room_left = CAP_RESET;
  logic [CapWidth-1:0] seg_left = '0;
  bit                  chunk_live = 1'b0;
  bit                  stream_ended = 1'b0;
  int                  burst_len;
  framed_byte_t        framed_q[$];

  bit steady = 1'b0;
  int errors = 0;
  int requests_sent = 0;
  int bytes_checked = 0;
  int chunks_ended = 0;
  int settings_written = 0;

  length_prefixed_chunk_framer u_dut (
    .clk               (clk),
    .rst               (rst),
    .chunk_capacity_we (chunk_capacity_we),
    .chunk_capacity    (chunk_capacity),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .command           (command),
    .data_byte         (data_byte),
    .write_remaining   (write_remaining),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .last              (last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  function automatic logic [WrWidth-1:0] rand_wr();
    return WrWidth'($urandom);
  endfunction

  function automatic void emit_byte(input logic [7:0] b);
    framed_q.push_back('{data: b, last: 1'b0});
    burst_len++;
  endfunction

  function automatic void emit_word(input logic [31:0] w);
    for (int k = 3; k >= 0; k--) emit_byte(w[8*k +: 8]);
    if (w == EndOfChunk) chunks_ended++;
  endfunction

  function automatic void open_chunk();
    chunk_live = 1'b1;
    room_left = (cfg_cap < CAP_MIN) ? CAP_MIN : cfg_cap;
    seg_left = '0;
  endfunction

  function automatic void predict_framing(input logic [1:0] cmd, input logic [7:0] b,
                                          input logic [WrWidth-1:0] wr);
    logic [31:0] avail;
    logic [31:0] want;
    logic [31:0] seg_len;
    burst_len = 0;
    if (stream_ended) return;
    case (cmd)
      CMD_DATA: begin
        if (seg_left == 0) begin
          if (!chunk_live || room_left <= 8) begin
            if (chunk_live) emit_word(EndOfChunk);
            open_chunk();
          end
          want = (wr == 0) ? 32'd1 : {1'b0, wr};
          avail = {14'd0, room_left} - 32'd8;
          seg_len = (want < avail) ? want : avail;
          emit_word(seg_len);
          room_left = room_left - 18'd4 - seg_len[CapWidth-1:0];
          seg_left = seg_len[CapWidth-1:0];
        end
        emit_byte(b);
        seg_left = seg_left - 18'd1;
      end
      CMD_FLUSH: begin
        if (chunk_live) emit_word(EndOfChunk);
        open_chunk();
      end
      CMD_CLOSE: begin
        if (chunk_live) begin
          if (room_left < 4) begin
            emit_word(EndOfChunk);
            open_chunk();
          end
          emit_word(EndOfStream);
          emit_word(EndOfChunk);
          chunk_live = 1'b0;
          stream_ended = 1'b1;
          seg_left = '0;
        end
      end
      default: ;
    endcase
    if (burst_len > 0) framed_q[framed_q.size()-1].last = 1'b1;
  endfunction

  // output side: random backpressure (none while steady) and comparison against the oldest expectation
  always @(posedge clk) begin
    framed_byte_t exp_b;
    if (!rst && out_valid && out_ready) begin
      if (framed_q.size() == 0) begin
        $display("%0t: unexpected output byte %02h last %0b", $time, out_byte, last);
        errors++;
      end else begin
        exp_b = framed_q.pop_front();
        bytes_checked++;
        if (out_byte !== exp_b.data) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, exp_b.data, out_byte);
          errors++;
        end
        if (last !== exp_b.last) begin
          $display("%0t: last expected %0b actual %0b", $time, exp_b.last, last);
          errors++;
        end
      end
    end
    out_ready <= steady || ($urandom_range(99) >= 35);
  end

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] b,
                           input logic [WrWidth-1:0] wr);
    while (!steady && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    data_byte <= b;
    write_remaining <= wr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_framing(cmd, b, wr);
    if (cmd != CmdUnused) requests_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (framed_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CapWidth-1:0] cap);
    wait_drained();
    chunk_capacity_we <= 1'b1;
    chunk_capacity <= cap;
    @(posedge clk);
    chunk_capacity_we <= 1'b0;
    cfg_cap = cap;
    settings_written++;
  endtask

  task automatic test_close_before_open();
    send_item(CMD_CLOSE, 8'h11, 31'd1);
    send_item(CmdUnused, 8'h22, 31'd1);
    send_item(CMD_FLUSH, 8'h33, 31'd1);
  endtask

  task automatic test_segment_corners();
    send_item(CMD_DATA, 8'h00, 31'd0);
    send_item(CMD_DATA, 8'hFF, 31'd1);
    send_item(CMD_DATA, 8'hA5, 31'h7FFF_FFFF);
    send_item(CMD_DATA, 8'h5A, 31'h7FFF_FFFE);
    // flush in mid-segment drops the rest
    send_item(CMD_FLUSH, 8'h00, 31'd1);
    for (int i = 3; i >= 1; i--) send_item(CMD_DATA, 8'(8'h3C + i), WrWidth'(i));
  endtask

  task automatic test_capacity_floor();
    write_capacity('0);
    send_item(CMD_FLUSH, 8'h00, 31'd1);
    for (int i = 10; i >= 1; i--) send_item(CMD_DATA, rand_byte(), WrWidth'(i));
  endtask

  task automatic test_random_framing(input logic [CapWidth-1:0] cap, input int goal,
                                     input bit no_idle);
    int sent;
    int len;
    int pick;
    write_capacity(cap);
    steady = no_idle;
    send_item(CMD_FLUSH, rand_byte(), rand_wr());
    sent = 1;
    while (sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(49) == 0) begin
            send_item(CMD_FLUSH, rand_byte(), rand_wr());
            sent++;
            break;
          end
          send_item(CMD_DATA, rand_byte(), WrWidth'(len - i));
          sent++;
        end
      end else if (pick < 82) begin
        send_item(CMD_FLUSH, rand_byte(), rand_wr());
        sent++;
      end else if (pick < 93) begin
        send_item(CMD_DATA, rand_byte(), rand_wr());
        sent++;
      end else begin
        send_item(CmdUnused, rand_byte(), rand_wr());
      end
    end
    steady = 1'b0;
  endtask

  task automatic test_close_and_after();
    write_capacity(18'd24);
    for (int i = 5; i >= 3; i--) send_item(CMD_DATA, rand_byte(), WrWidth'(i));
    // close in mid-segment, then everything is ignored
    send_item(CMD_CLOSE, rand_byte(), rand_wr());
    send_item(CMD_DATA, rand_byte(), 31'd4);
    send_item(CMD_FLUSH, rand_byte(), rand_wr());
    send_item(CMD_CLOSE, rand_byte(), rand_wr());
    send_item(CmdUnused, rand_byte(), rand_wr());
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_close_before_open();
    test_segment_corners();
    test_capacity_floor();
    test_random_framing(CAP_MIN, 38, 1'b0);
    test_random_framing(18'h3FFFF, 38, 1'b0);
    test_random_framing(18'd20, 38, 1'b1);
    test_random_framing(18'd13, 38, 1'b0);
    test_random_framing(18'd37, 38, 1'b0);
    test_random_framing(CapWidth'($urandom_range(12, 300)), 38, 1'b0);
    test_random_framing(CAP_RESET, 38, 1'b0);
    test_random_framing(18'd5, 38, 1'b0);
    test_close_and_after();
    $display("run covered %0d requests and %0d checked output bytes", requests_sent,
             bytes_checked);
    $display("across %0d capacity settings, %0d chunks ended, stream closed once",
             settings_written, chunks_ended);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
